// File: src/cmt_pkg.sv
// Shared types, constants and functions for the cylinder mesh tessellator.
// Depends on nothing; every other file in src imports it.
package cmt_pkg;

  localparam int TURN_W = 24;
  localparam int TRIG_W = 17;
  localparam int LANES  = 4;

  // lane order: cos a0, sin a0, cos a1, sin a1
  localparam int LANE_X0 = 0;
  localparam int LANE_Y0 = 1;
  localparam int LANE_X1 = 2;
  localparam int LANE_Y1 = 3;

  localparam logic [TURN_W-1:0] QUARTER_TURN = 24'h40_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [30:0] RADIUS_MIN      = 31'd655;
  localparam logic [29:0] HALF_HEIGHT_MIN = 30'd328;
  localparam logic [8:0]  SUBDIV_MIN      = 9'd3;

  localparam logic [3:0] SLOT_FIRST = 4'd0;
  localparam logic [3:0] SLOT_LAST  = 4'd11;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_SUBDIV      = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_RED         = 3'd4,
    REG_GREEN       = 3'd5,
    REG_BLUE        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [30:0] radius;
    logic [29:0] half_height;
    logic [8:0]  subdivisions;
    logic [22:0] angle_step;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } cfg_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             bad;
  } trig_flags_t;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               bad;
  } ring_word_t;

  typedef enum logic [1:0] {
    PT_CENTRE,
    PT_RING0,
    PT_RING1
  } point_sel_t;

  typedef struct packed {
    logic       top;
    point_sel_t point;
  } slot_shape_t;

  // top cap, bottom cap, then the two side triangles
  function automatic slot_shape_t slot_shape(input logic [3:0] slot);
    slot_shape_t s;
    case (slot)
      4'd0:    s = '{top: 1'b1, point: PT_CENTRE};
      4'd1:    s = '{top: 1'b1, point: PT_RING0};
      4'd2:    s = '{top: 1'b1, point: PT_RING1};
      4'd3:    s = '{top: 1'b0, point: PT_CENTRE};
      4'd4:    s = '{top: 1'b0, point: PT_RING1};
      4'd5:    s = '{top: 1'b0, point: PT_RING0};
      4'd6:    s = '{top: 1'b0, point: PT_RING0};
      4'd7:    s = '{top: 1'b0, point: PT_RING1};
      4'd8:    s = '{top: 1'b1, point: PT_RING0};
      4'd9:    s = '{top: 1'b1, point: PT_RING0};
      4'd10:   s = '{top: 1'b0, point: PT_RING1};
      4'd11:   s = '{top: 1'b1, point: PT_RING1};
      default: s = '{top: 1'b1, point: PT_CENTRE};
    endcase
    return s;
  endfunction

  // Taylor series in Q2.30 up to x^15, rounded to Q16 and capped at one.
  // Evaluated on constants only, to build the quarter-wave table.
  function automatic logic [TRIG_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    v    = (sum + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[TRIG_W-1:0];
  endfunction

endpackage

// File: src/cmt_front.sv
// Front end: ring angles of a slice, then quadrant folding and table index.
// Two register stages; depends on cmt_pkg.
module cmt_front
  import cmt_pkg::*;
#(
  parameter int MAX_SEGMENTS       = 360,
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int IW                 = $clog2(SINE_TABLE_ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       seg_valid,
  output logic                       seg_ready,
  input  logic [8:0]                 segment_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LANES-1:0][IW-1:0]   out_idx,
  output trig_flags_t                out_flags
);

  localparam int PW = IW + 23;

  logic              v1;
  logic [TURN_W-1:0] a0;
  logic [TURN_W-1:0] a1;
  logic              bad1;
  logic              en1;
  logic              en2;

  logic [8:0]        subs_eff;
  logic [9:0]        idx_plus;
  logic              bad_c;
  logic              last_c;
  logic [31:0]       prod0;
  logic [31:0]       prod1;

  logic [LANES-1:0][TURN_W-1:0] ang;
  logic [LANES-1:0][IW-1:0]     idx_c;
  logic [LANES-1:0]             neg_c;
  logic [22:0]                  u;
  logic [PW-1:0]                uprod;

  assign en2       = !out_valid || out_ready;
  assign en1       = !v1 || en2;
  assign seg_ready = en1;

  always_comb begin
    if (cfg.subdivisions < SUBDIV_MIN) begin
      subs_eff = SUBDIV_MIN;
    end else if (32'(cfg.subdivisions) > MAX_SEGMENTS) begin
      subs_eff = 9'(MAX_SEGMENTS);
    end else begin
      subs_eff = cfg.subdivisions;
    end
    idx_plus = {1'b0, segment_index} + 10'd1;
    bad_c    = segment_index >= subs_eff;
    last_c   = idx_plus >= {1'b0, subs_eff};
    prod0    = 32'(segment_index) * 32'(cfg.angle_step);
    prod1    = 32'(idx_plus) * 32'(cfg.angle_step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a0   <= prod0[TURN_W-1:0];
      a1   <= last_c ? '0 : prod1[TURN_W-1:0];
      bad1 <= bad_c;
    end
  end

  // cos(a) = sin(a + quarter turn); fold each angle into the first quadrant
  always_comb begin
    ang[LANE_X0] = a0 + QUARTER_TURN;
    ang[LANE_Y0] = a0;
    ang[LANE_X1] = a1 + QUARTER_TURN;
    ang[LANE_Y1] = a1;
    u     = '0;
    uprod = '0;
    for (int l = 0; l < LANES; l++) begin
      if (ang[l][22]) begin
        u = {1'b1, 22'd0} - {1'b0, ang[l][21:0]};
      end else begin
        u = {1'b0, ang[l][21:0]};
      end
      uprod    = PW'(u) * PW'(SINE_TABLE_ENTRIES);
      idx_c[l] = uprod[22 +: IW];
      neg_c[l] = ang[l][23];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_idx       <= idx_c;
      out_flags.neg <= neg_c;
      out_flags.bad <= bad1;
    end
  end

endmodule

// File: src/cmt_sine_rom.sv
// Quarter-wave sine table split into banks of up to 256 entries.
// Stage one reads every bank, stage two picks the bank; depends on cmt_pkg.
module cmt_sine_rom
  import cmt_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int IW                 = $clog2(SINE_TABLE_ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [LANES-1:0][IW-1:0]      in_idx,
  input  trig_flags_t                   in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [LANES-1:0][TRIG_W-1:0]  out_trig,
  output trig_flags_t                   out_flags
);

  localparam int BANK_W     = (IW < 8) ? IW : 8;
  localparam int BANK_DEPTH = 1 << BANK_W;
  localparam int NB         = (SINE_TABLE_ENTRIES + BANK_DEPTH) / BANK_DEPTH;
  localparam int HIW        = (IW > BANK_W) ? (IW - BANK_W) : 1;

  logic [TRIG_W-1:0] bank_rom [NB][BANK_DEPTH];

  for (genvar b = 0; b < NB; b++) begin : g_bank
    for (genvar e = 0; e < BANK_DEPTH; e++) begin : g_ent
      localparam int K = b * BANK_DEPTH + e;
      if (K <= SINE_TABLE_ENTRIES) begin : g_live
        localparam logic [63:0] XQ = (HALF_PI_Q30 * 64'(K)) / 64'(SINE_TABLE_ENTRIES);
        assign bank_rom[b][e] = sine_q16(XQ);
      end else begin : g_pad
        assign bank_rom[b][e] = '0;
      end
    end
  end

  logic                 v3;
  logic [TRIG_W-1:0]    cand [LANES][NB];
  logic [HIW-1:0]       hi   [LANES];
  trig_flags_t          flags3;
  logic                 en3;
  logic                 en4;
  logic [LANES-1:0][TRIG_W-1:0] trig_c;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int l = 0; l < LANES; l++) begin
        hi[l] <= HIW'(in_idx[l] >> BANK_W);
        for (int b = 0; b < NB; b++) begin
          cand[l][b] <= bank_rom[b][in_idx[l][BANK_W-1:0]];
        end
      end
      flags3 <= in_flags;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trig_c[l] = '0;
      for (int b = 0; b < NB; b++) begin
        if (hi[l] == HIW'(b)) begin
          trig_c[l] = cand[l][b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_trig  <= trig_c;
      out_flags <= flags3;
    end
  end

endmodule

// File: src/cmt_scale.sv
// Radius scaling: multiply by the radius, then round, apply sign.
// Two register stages; depends on cmt_pkg.
module cmt_scale
  import cmt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [LANES-1:0][TRIG_W-1:0]  in_trig,
  input  trig_flags_t                   in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ring_word_t                    out_word
);

  logic                    v5;
  logic [LANES-1:0][47:0]  prod;
  trig_flags_t             flags5;
  logic                    en5;
  logic                    en6;
  logic [30:0]             rad_eff;
  logic [47:0]             rounded;
  logic [31:0]             mag;
  logic [LANES-1:0][31:0]  coord;

  assign en6      = !out_valid || out_ready;
  assign en5      = !v5 || en6;
  assign in_ready = en5;

  assign rad_eff = (cfg.radius < RADIUS_MIN) ? RADIUS_MIN : cfg.radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int l = 0; l < LANES; l++) begin
        prod[l] <= 48'(in_trig[l]) * 48'(rad_eff);
      end
      flags5 <= in_flags;
    end
  end

  // round half up on the magnitude, negate afterwards
  always_comb begin
    rounded = '0;
    mag     = '0;
    for (int l = 0; l < LANES; l++) begin
      rounded  = prod[l] + 48'd32768;
      mag      = rounded[47:16];
      coord[l] = flags5.neg[l] ? (32'd0 - mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en6) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_word.x0  <= signed'(coord[LANE_X0]);
      out_word.y0  <= signed'(coord[LANE_Y0]);
      out_word.x1  <= signed'(coord[LANE_X1]);
      out_word.y1  <= signed'(coord[LANE_Y1]);
      out_word.bad <= flags5.bad;
    end
  end

endmodule

// File: src/cmt_emit.sv
// Vertex sequencer: holds one slice and sends its vertices through the
// output register one word a cycle while vert_ready is high. Depends on cmt_pkg.
module cmt_emit
  import cmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  ring_word_t         in_word,
  output logic               vert_valid,
  input  logic               vert_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [15:0]        vert_red,
  output logic [15:0]        vert_green,
  output logic [15:0]        vert_blue,
  output logic [3:0]         vertex_slot,
  output logic               bad_index,
  output logic               last_vertex
);

  logic        busy;
  logic [3:0]  slot;
  ring_word_t  slice;
  logic        load;
  logic        fin;
  logic        take;

  slot_shape_t        shape;
  logic [29:0]        hh_eff;
  logic signed [31:0] zt;
  logic signed [31:0] x_c;
  logic signed [31:0] y_c;
  logic signed [31:0] z_c;
  logic [15:0]        r_c;
  logic [15:0]        g_c;
  logic [15:0]        b_c;
  logic [3:0]         slot_c;
  logic               last_c;

  assign load     = busy && (!vert_valid || vert_ready);
  assign fin      = load && (slice.bad || slot == SLOT_LAST);
  assign in_ready = !busy || fin;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      slot       <= SLOT_FIRST;
      vert_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        slot <= SLOT_FIRST;
      end else begin
        if (fin) begin
          busy <= 1'b0;
        end
        if (load) begin
          slot <= slot + 4'd1;
        end
      end
      if (load) begin
        vert_valid <= 1'b1;
      end else if (vert_ready) begin
        vert_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slice <= in_word;
    end
  end

  always_comb begin
    shape  = slot_shape(slot);
    hh_eff = (cfg.half_height < HALF_HEIGHT_MIN) ? HALF_HEIGHT_MIN : cfg.half_height;
    zt     = signed'({2'b00, hh_eff});
    z_c    = shape.top ? zt : -zt;
    case (shape.point)
      PT_RING0: begin
        x_c = slice.x0;
        y_c = slice.y0;
      end
      PT_RING1: begin
        x_c = slice.x1;
        y_c = slice.y1;
      end
      default: begin
        x_c = '0;
        y_c = '0;
      end
    endcase
    r_c    = cfg.color_red;
    g_c    = cfg.color_green;
    b_c    = cfg.color_blue;
    slot_c = slot;
    last_c = slot == SLOT_LAST;
    // a flagged slice sends one blank word
    if (slice.bad) begin
      x_c    = '0;
      y_c    = '0;
      z_c    = '0;
      r_c    = '0;
      g_c    = '0;
      b_c    = '0;
      slot_c = SLOT_FIRST;
      last_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x       <= x_c;
      pos_y       <= y_c;
      pos_z       <= z_c;
      vert_red    <= r_c;
      vert_green  <= g_c;
      vert_blue   <= b_c;
      vertex_slot <= slot_c;
      bad_index   <= slice.bad;
      last_vertex <= last_c;
    end
  end

endmodule

// File: src/cylinder_mesh_tessellator.sv
// Top level of the capped cylinder tessellator: configuration registers and
// the pipeline cmt_front -> cmt_sine_rom -> cmt_scale -> cmt_emit (cmt_pkg).
//
//   channel   signals                         direction  word
//   segment   seg_valid / seg_ready           in         segment_index
//   vertex    vert_valid / vert_ready         out        pos, colour, slot, flags
//   config    cfg_we, cfg_index, cfg_data     in         one register write
//
// Each accepted segment with a good index gives twelve vertex words, one a
// cycle while vert_ready is high; the vertex sequencer in cmt_emit sets that
// rate. A bad index gives one blank word. Six register stages sit ahead of the
// sequencer. Synchronous reset clears the valid bits and loads the register
// defaults. With vert_ready low every stage holds; segments keep being taken
// until all six stages are full.
module cylinder_mesh_tessellator
  import cmt_pkg::*;
#(
  parameter int MAX_SEGMENTS       = 360,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  logic [8:0]         segment_index,
  output logic               vert_valid,
  input  logic               vert_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [15:0]        vert_red,
  output logic [15:0]        vert_green,
  output logic [15:0]        vert_blue,
  output logic [3:0]         vertex_slot,
  output logic               bad_index,
  output logic               last_vertex
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius       <= 31'd65536;
      cfg.half_height  <= 30'd32768;
      cfg.subdivisions <= 9'd3;
      cfg.angle_step   <= 23'd5592405;
      cfg.color_red    <= 16'hFFFF;
      cfg.color_green  <= 16'hFFFF;
      cfg.color_blue   <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:      cfg.radius       <= cfg_data;
        REG_HALF_HEIGHT: cfg.half_height  <= cfg_data[29:0];
        REG_SUBDIV:      cfg.subdivisions <= cfg_data[8:0];
        REG_ANGLE_STEP:  cfg.angle_step   <= cfg_data[22:0];
        REG_RED:         cfg.color_red    <= cfg_data[15:0];
        REG_GREEN:       cfg.color_green  <= cfg_data[15:0];
        REG_BLUE:        cfg.color_blue   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  logic                         idx_valid;
  logic                         idx_ready;
  logic [LANES-1:0][IW-1:0]     idx;
  trig_flags_t                  idx_flags;
  logic                         trig_valid;
  logic                         trig_ready;
  logic [LANES-1:0][TRIG_W-1:0] trig;
  trig_flags_t                  trig_flags;
  logic                         ring_valid;
  logic                         ring_ready;
  ring_word_t                   ring;

  cmt_front #(
    .MAX_SEGMENTS       (MAX_SEGMENTS),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .IW                 (IW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .seg_valid     (seg_valid),
    .seg_ready     (seg_ready),
    .segment_index (segment_index),
    .out_valid     (idx_valid),
    .out_ready     (idx_ready),
    .out_idx       (idx),
    .out_flags     (idx_flags)
  );

  cmt_sine_rom #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .IW                 (IW)
  ) u_sine_rom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (idx_valid),
    .in_ready  (idx_ready),
    .in_idx    (idx),
    .in_flags  (idx_flags),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_trig  (trig),
    .out_flags (trig_flags)
  );

  cmt_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_trig   (trig),
    .in_flags  (trig_flags),
    .out_valid (ring_valid),
    .out_ready (ring_ready),
    .out_word  (ring)
  );

  cmt_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (ring_valid),
    .in_ready    (ring_ready),
    .in_word     (ring),
    .vert_valid  (vert_valid),
    .vert_ready  (vert_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .vert_red    (vert_red),
    .vert_green  (vert_green),
    .vert_blue   (vert_blue),
    .vertex_slot (vertex_slot),
    .bad_index   (bad_index),
    .last_vertex (last_vertex)
  );

`ifndef SYNTHESIS
  // no gap inside a slice: the next word is loaded as the current one leaves
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_ready && !last_vertex |=> vert_valid)
    else $error("vertex stream broke inside a slice");

  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_ready && !last_vertex
    |=> vertex_slot == 4'($past(vertex_slot) + 4'd1))
    else $error("vertex slot did not advance by one");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    vert_valid && last_vertex |->
    (bad_index && vertex_slot == SLOT_FIRST) || (!bad_index && vertex_slot == SLOT_LAST))
    else $error("final word of a slice in the wrong slot");
`endif

endmodule

// File: test/cmt_tb_pkg.sv
// Scoreboard for the cylinder mesh tessellator bench: predicts the vertex
// words of every slice (twelve, or one for a bad index) and checks the words the block sends back.
// Depends on cmt_pkg for the register codes.
`timescale 1ns / 100ps
package cmt_tb_pkg;
  import cmt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned SUBS_FLOOR    = 3;
  localparam int unsigned SUBS_CEIL     = 360;
  localparam logic [30:0] RAD_FLOOR     = 31'd655;
  localparam logic [29:0] HH_FLOOR      = 30'd328;
  localparam logic [23:0] QTR_TURN      = 24'h40_0000;
  localparam logic [63:0] HALF_PI_FIX   = 64'd1686629713;
  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  localparam int          REPORT_CAP    = 100;

  typedef enum {AT_CENTRE, AT_RING0, AT_RING1} ring_point_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [3:0]  slot;
    logic        bad;
    logic        last;
  } vertex_t;

  function automatic int unsigned clamp_subdivisions(input logic [8:0] s);
    if (s < SUBS_FLOOR) return SUBS_FLOOR;
    if (s > SUBS_CEIL) return SUBS_CEIL;
    return 32'(s);
  endfunction

  class vertex_scoreboard_t;
    logic [30:0] radius;
    logic [29:0] half_height;
    logic [8:0]  subdivisions;
    logic [22:0] angle_step;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic [16:0] sine_tab [TABLE_ENTRIES+1];
    vertex_t     pending [$];
    int          errors;
    int          segments_seen;
    int          bad_seen;
    int          vertices_checked;
    int          reg_writes;

    function new();
      radius           = 31'd65536;
      half_height      = 30'd32768;
      subdivisions     = 9'd3;
      angle_step       = 23'd5592405;
      color_red        = 16'hFFFF;
      color_green      = 16'hFFFF;
      color_blue       = 16'hFFFF;
      errors           = 0;
      segments_seen    = 0;
      bad_seen         = 0;
      vertices_checked = 0;
      reg_writes       = 0;
      build_sine_table();
    endfunction

    // quarter-wave sine, Taylor series in Q2.30, rounded to Q16
    function void build_sine_table();
      logic [63:0] x, x2, term, acc, v;
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
        x    = (HALF_PI_FIX * 64'(k)) / 64'(TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
          if (n % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        v = (acc + 64'd8192) >> 14;
        if (v > 64'd65536) begin
          v = 64'd65536;
        end
        sine_tab[k] = v[16:0];
      end
    endfunction

    // sine of angle a (Q0.24 turns) times rad, rounded on the magnitude
    function logic [31:0] ring_coord(input logic [23:0] a, input logic [30:0] rad);
      logic [22:0] u;
      logic [63:0] idx, m;
      u   = a[22] ? (QTR_TURN[22:0] - {1'b0, a[21:0]}) : {1'b0, a[21:0]};
      idx = (64'(u) * 64'(TABLE_ENTRIES)) >> 22;
      if (idx > 64'(TABLE_ENTRIES)) begin
        idx = 64'(TABLE_ENTRIES);
      end
      m = (64'(sine_tab[idx]) * 64'(rad) + 64'd32768) >> 16;
      return a[23] ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [30:0] val);
      reg_writes++;
      case (idx)
        REG_RADIUS:      radius       = val;
        REG_HALF_HEIGHT: half_height  = val[29:0];
        REG_SUBDIV:      subdivisions = val[8:0];
        REG_ANGLE_STEP:  angle_step   = val[22:0];
        REG_RED:         color_red    = val[15:0];
        REG_GREEN:       color_green  = val[15:0];
        REG_BLUE:        color_blue   = val[15:0];
        default: ;
      endcase
    endfunction

    // append one expected word behind those already waiting
    function void queue_vertex(input vertex_t v);
      pending = {pending, v};
    endfunction

    function void note_segment(input logic [8:0] seg);
      int unsigned subs, i;
      logic [30:0] rad;
      logic [29:0] hh;
      logic [63:0] prod;
      logic [23:0] a0, a1;
      logic [31:0] x0, y0, x1, y1, zt, zb;
      vertex_t     v;
      bit          top;
      ring_point_t pt;
      segments_seen++;
      subs = clamp_subdivisions(subdivisions);
      i    = 32'(seg);
      if (i >= subs) begin
        bad_seen++;
        v      = '0;
        v.bad  = 1'b1;
        v.last = 1'b1;
        queue_vertex(v);
        return;
      end
      rad  = (radius < RAD_FLOOR) ? RAD_FLOOR : radius;
      hh   = (half_height < HH_FLOOR) ? HH_FLOOR : half_height;
      prod = 64'(i) * 64'(angle_step);
      a0   = prod[23:0];
      // the last slice closes the ring at angle zero
      prod = 64'(i + 1) * 64'(angle_step);
      a1   = (i + 1 >= subs) ? 24'd0 : prod[23:0];
      x0   = ring_coord(a0 + QTR_TURN, rad);
      y0   = ring_coord(a0, rad);
      x1   = ring_coord(a1 + QTR_TURN, rad);
      y1   = ring_coord(a1, rad);
      zt   = {2'b00, hh};
      zb   = 32'd0 - zt;
      for (int k = 0; k < 12; k++) begin
        case (k)
          0:       begin top = 1'b1; pt = AT_CENTRE; end
          1, 8, 9: begin top = 1'b1; pt = AT_RING0;  end
          2, 11:   begin top = 1'b1; pt = AT_RING1;  end
          3:       begin top = 1'b0; pt = AT_CENTRE; end
          5, 6:    begin top = 1'b0; pt = AT_RING0;  end
          default: begin top = 1'b0; pt = AT_RING1;  end
        endcase
        v.pos_x = (pt == AT_RING0) ? x0 : (pt == AT_RING1) ? x1 : 32'd0;
        v.pos_y = (pt == AT_RING0) ? y0 : (pt == AT_RING1) ? y1 : 32'd0;
        v.pos_z = top ? zt : zb;
        v.red   = color_red;
        v.green = color_green;
        v.blue  = color_blue;
        v.slot  = 4'(k);
        v.bad   = 1'b0;
        v.last  = (k == 11);
        queue_vertex(v);
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task compare_field(input string name, input logic [31:0] seen, input logic [31:0] wanted);
      if (seen !== wanted) begin
        report($sformatf("word %0d %s: got %h, want %h", vertices_checked, name, seen, wanted));
      end
    endtask

    task check_vertex(input vertex_t got);
      vertex_t want;
      if (pending.size() == 0) begin
        report($sformatf("vertex word with nothing pending: slot %0d bad %0b",
                         got.slot, got.bad));
        return;
      end
      want = pending.pop_front();
      vertices_checked++;
      compare_field("pos_x", got.pos_x, want.pos_x);
      compare_field("pos_y", got.pos_y, want.pos_y);
      compare_field("pos_z", got.pos_z, want.pos_z);
      compare_field("vert_red", 32'(got.red), 32'(want.red));
      compare_field("vert_green", 32'(got.green), 32'(want.green));
      compare_field("vert_blue", 32'(got.blue), 32'(want.blue));
      compare_field("vertex_slot", 32'(got.slot), 32'(want.slot));
      compare_field("bad_index", 32'(got.bad), 32'(want.bad));
      compare_field("last_vertex", 32'(got.last), 32'(want.last));
    endtask
  endclass

endpackage

// File: test/cylinder_mesh_tessellator_tb.sv
// Top of the cylinder mesh tessellator bench: clock, reset, segment and
// register drivers and the vertex sink. Depends on cmt_pkg and cmt_tb_pkg.
`timescale 1ns / 100ps
module cylinder_mesh_tessellator_tb;
  import cmt_pkg::*;
  import cmt_tb_pkg::*;

  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 28;
  localparam int BURST_ITEMS   = 20;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;
  logic               seg_valid;
  logic               seg_ready;
  logic [8:0]         segment_index;
  logic               vert_valid;
  logic               vert_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        vert_red;
  logic [15:0]        vert_green;
  logic [15:0]        vert_blue;
  logic [3:0]         vertex_slot;
  logic               bad_index;
  logic               last_vertex;

  logic               hold_req;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  vertex_scoreboard_t sb = new();

  cylinder_mesh_tessellator dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d vertex words outstanding", sb.pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // vertex sink: check every accepted word, stall at random or on request
  initial begin : vertex_sink
    int      hold_left;
    bit      hold_taken;
    vertex_t got;
    hold_left  = 0;
    hold_taken = 1'b0;
    vert_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && vert_valid && vert_ready) begin
        got.pos_x = pos_x;
        got.pos_y = pos_y;
        got.pos_z = pos_z;
        got.red   = vert_red;
        got.green = vert_green;
        got.blue  = vert_blue;
        got.slot  = vertex_slot;
        got.bad   = bad_index;
        got.last  = last_vertex;
        sb.check_vertex(got);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        vert_ready <= 1'b0;
      end else begin
        vert_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one segment word; valid stays high when the next word follows at once
  task send_segment(input logic [8:0] seg);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg_valid     <= 1'b1;
    segment_index <= seg;
    do @(posedge clk); while (!seg_ready);
    sb.note_segment(seg);
  endtask

  task put_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task load_config(input logic [30:0] rad, input logic [29:0] hh, input logic [8:0] subs,
                   input logic [22:0] ang_step, input logic [15:0] r, input logic [15:0] g,
                   input logic [15:0] b);
    put_reg(REG_RADIUS, rad);
    put_reg(REG_HALF_HEIGHT, 31'(hh));
    put_reg(REG_SUBDIV, 31'(subs));
    put_reg(REG_ANGLE_STEP, 31'(ang_step));
    put_reg(REG_RED, 31'(r));
    put_reg(REG_GREEN, 31'(g));
    put_reg(REG_BLUE, 31'(b));
    // no register behind this index; the write must change nothing
    put_reg(REG_UNUSED, 31'($urandom));
    cfg_we <= 1'b0;
  endtask

  task wait_for_vertices();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task random_config();
    logic [30:0]  rad;
    logic [29:0]  hh;
    logic [8:0]   subs;
    logic [22:0]  ang_step;
    int unsigned  es;
    case ($urandom_range(9))
      0:       subs = 9'($urandom_range(0, 2));
      1:       subs = 9'($urandom_range(361, 511));
      2:       subs = 9'(SUBS_CEIL);
      3:       subs = 9'(SUBS_FLOOR);
      default: subs = 9'($urandom_range(3, 360));
    endcase
    es = clamp_subdivisions(subs);
    if ($urandom_range(4) == 0) begin
      ang_step = 23'($urandom);
    end else begin
      ang_step = 23'(((1 << 24) + es / 2) / es);
    end
    case ($urandom_range(4))
      0:       rad = 31'($urandom_range(0, 654));
      1:       rad = 31'($urandom_range(655, 1 << 20));
      default: rad = 31'($urandom);
    endcase
    case ($urandom_range(4))
      0:       hh = 30'($urandom_range(0, 327));
      1:       hh = 30'($urandom_range(328, 1 << 20));
      default: hh = 30'($urandom);
    endcase
    load_config(rad, hh, subs, ang_step, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // mostly slices on the ring, some closing slices, the rest anywhere
  function logic [8:0] pick_index();
    int unsigned es;
    es = clamp_subdivisions(sb.subdivisions);
    case ($urandom_range(19))
      0, 1:    return 9'($urandom_range(0, 511));
      2:       return 9'(es - 1);
      default: return 9'($urandom_range(0, es - 1));
    endcase
  endfunction

  task run_random(input int count);
    random_config();
    for (int i = 0; i < count; i++) begin
      send_segment(pick_index());
    end
    seg_valid <= 1'b0;
    wait_for_vertices();
  endtask

  initial begin : stimulus
    logic [8:0] sweep [10] = '{9'd0, 9'd1, 9'd89, 9'd90, 9'd180, 9'd270, 9'd358, 9'd359,
                               9'd360, 9'd511};
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_RADIUS;
    cfg_data      <= '0;
    seg_valid     <= 1'b0;
    segment_index <= '0;
    hold_req      <= 1'b0;
    recv_idle_pct <= 0;
    send_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: three slices, the last closing at angle zero, then past the ring
    send_segment(9'd0);
    send_segment(9'd1);
    send_segment(9'd2);
    send_segment(9'd3);
    send_segment(9'd511);
    seg_valid <= 1'b0;
    wait_for_vertices();

    // widest radius and height on the finest ring
    load_config(31'h7FFF_FFFF, 30'h3FFF_FFFF, 9'd360, 23'd46603, 16'h0000, 16'hFFFF, 16'h5A5A);
    foreach (sweep[i]) begin
      send_segment(sweep[i]);
    end
    seg_valid <= 1'b0;
    wait_for_vertices();

    // floors: zero radius, height and ring size; odd angle step of all ones
    load_config(31'd0, 30'd0, 9'd0, 23'h7F_FFFF, 16'hFFFF, 16'h0000, 16'hA5A5);
    send_segment(9'd0);
    send_segment(9'd1);
    send_segment(9'd2);
    send_segment(9'd3);
    seg_valid <= 1'b0;
    wait_for_vertices();

    // ring size above the ceiling, zero step so every angle is zero
    load_config(31'd655, 30'd328, 9'd511, 23'd0, 16'h1234, 16'h8001, 16'hFFFF);
    send_segment(9'd0);
    send_segment(9'd359);
    send_segment(9'd360);
    seg_valid <= 1'b0;
    wait_for_vertices();

    // long sink stall while the sender keeps offering, then drain fully
    random_config();
    hold_req <= 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_segment(pick_index());
    end
    seg_valid <= 1'b0;
    wait_for_vertices();

    send_idle_pct = 31;
    recv_idle_pct <= 69;
    run_random(PHASE_ITEMS);
    run_random(PHASE_ITEMS);
    send_idle_pct = 69;
    recv_idle_pct <= 31;
    run_random(PHASE_ITEMS);
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(PHASE_ITEMS);
    run_random(PHASE_ITEMS);

    $display("covered %0d slices (%0d past the ring) over %0d register writes",
             sb.segments_seen, sb.bad_seen, sb.reg_writes);
    $display("checked %0d vertex words under both-side stalls, %0d mismatches",
             sb.vertices_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cmt_pkg.sv
src/cmt_front.sv
src/cmt_sine_rom.sv
src/cmt_scale.sv
src/cmt_emit.sv
src/cylinder_mesh_tessellator.sv
test/cmt_tb_pkg.sv
test/cylinder_mesh_tessellator_tb.sv
